/* design/cmdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdc_pkg
// Shared types and constants for the motorized cover drive controller.
// ----------------------------------------------------------------------------
package cmdc_pkg;

  localparam int POS_W   = 11;
  localparam int TIMER_W = 16;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 2;

  localparam logic [POS_W-1:0]   FULL_SCALE = 11'd1024;
  localparam logic [TIMER_W-1:0] TIMER_MAX  = 16'hFFFF;

  // item kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_STOP = 2'd1;
  localparam logic [1:0] KIND_MOVE = 2'd2;

  // motion codes
  localparam logic [1:0] MOT_IDLE    = 2'd0;
  localparam logic [1:0] MOT_OPENING = 2'd1;
  localparam logic [1:0] MOT_CLOSING = 2'd2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_NEAR_END_POWER    = 2'd0;
  localparam logic [IDX_W-1:0] REG_TARGET_TOLERANCE  = 2'd1;
  localparam logic [IDX_W-1:0] REG_STALL_LIMIT_MS    = 2'd2;
  localparam logic [IDX_W-1:0] REG_PUBLISH_PERIOD_MS = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0]   near_end_power;
    logic [POS_W-1:0]   target_tolerance;
    logic [TIMER_W-1:0] stall_limit_ms;
    logic [TIMER_W-1:0] publish_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         motion_state;
    logic [POS_W-1:0]   target_reg;
    logic [POS_W-1:0]   position_reg;
    logic [POS_W-1:0]   previous_position;
    logic [TIMER_W-1:0] stall_timer;
    logic               stall_armed;
    logic [TIMER_W-1:0] publish_timer;
    logic [POS_W-1:0]   open_duty;
    logic [POS_W-1:0]   close_duty;
  } state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [POS_W-1:0] sensed_position;
    logic [POS_W-1:0] goal_position;
    logic             at_open_end;
    logic             near_open_end;
    logic             at_closed_end;
    logic             near_closed_end;
  } item_t;

  typedef struct packed {
    logic publish;
    logic forced_stop;
  } flags_t;

  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] v);
    clamp_pos = (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

endpackage

/* design/cover_motor_drive_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cover_motor_drive_controller
// Two-direction motorized cover drive: ticks, stop and move commands.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | kind, positions, end-stop flags
//  out     | output    | out_valid / out_stall| drives, motion, position, flags
//  cfg     | input     | cfg_wr_en            | cfg_index, cfg_data
//
//  One item per cycle while out is not stalled; each item passes the input
//  register, then state update and result register in one pass.
//  Synchronous active-high reset clears state and valid flags and loads register defaults.
//  A stall on out holds the result register; the input register then fills
//  and in_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module cover_motor_drive_controller import cmdc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [POS_W-1:0]   sensed_position,
  input  logic [POS_W-1:0]   goal_position,
  input  logic               at_open_end,
  input  logic               near_open_end,
  input  logic               at_closed_end,
  input  logic               near_closed_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [POS_W-1:0]   open_drive,
  output logic [POS_W-1:0]   close_drive,
  output logic [1:0]         motion,
  output logic [POS_W-1:0]   reported_position,
  output logic               publish,
  output logic               forced_stop
);

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  flags_t flags;
  item_t  s1_item;
  logic   s1_valid;
  logic   out_ready;
  logic   advance;
  logic   in_take;

  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_end_power    <= 11'd512;
      cfg.target_tolerance  <= 11'd102;
      cfg.stall_limit_ms    <= 16'd4000;
      cfg.publish_period_ms <= 16'd1000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NEAR_END_POWER:    cfg.near_end_power    <= cfg_data[POS_W-1:0];
        REG_TARGET_TOLERANCE:  cfg.target_tolerance  <= cfg_data[POS_W-1:0];
        REG_STALL_LIMIT_MS:    cfg.stall_limit_ms    <= cfg_data[TIMER_W-1:0];
        REG_PUBLISH_PERIOD_MS: cfg.publish_period_ms <= cfg_data[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.kind            <= kind;
      s1_item.sensed_position <= sensed_position;
      s1_item.goal_position   <= goal_position;
      s1_item.at_open_end     <= at_open_end;
      s1_item.near_open_end   <= near_open_end;
      s1_item.at_closed_end   <= at_closed_end;
      s1_item.near_closed_end <= near_closed_end;
    end
  end

  cmdc_step u_step (
    .cur   (state),
    .cfg   (cfg),
    .item  (s1_item),
    .nxt   (state_next),
    .flags (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance) begin
      open_drive        <= state_next.open_duty;
      close_drive       <= state_next.close_duty;
      motion            <= state_next.motion_state;
      reported_position <= state_next.position_reg;
      publish           <= flags.publish;
      forced_stop       <= flags.forced_stop;
    end
  end

  a_forced_implies_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && forced_stop |-> publish && motion == MOT_IDLE)
    else $error("forced stop without publish or idle motion");

  a_drives_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (open_drive == '0 || close_drive == '0))
    else $error("both drives active");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (open_drive <= FULL_SCALE && close_drive <= FULL_SCALE))
    else $error("drive duty above full scale");

  a_state_motion_code: assert property (@(posedge clk) disable iff (rst)
    advance |=> state.motion_state == motion)
    else $error("state and reported motion differ");

endmodule

/* design/cmdc_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdc_step
// Next-state and result logic for one item: tick, stop or move.
// ----------------------------------------------------------------------------
module cmdc_step import cmdc_pkg::*; (
  input  state_t cur,
  input  cfg_t   cfg,
  input  item_t  item,
  output state_t nxt,
  output flags_t flags
);

  logic [POS_W-1:0]   power;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   goal;
  logic [POS_W:0]     pos_plus_tol;
  logic [POS_W:0]     tgt_plus_tol;
  logic [TIMER_W-1:0] pub_cnt;

  always_comb begin
    power        = clamp_pos(cfg.near_end_power);
    pos          = clamp_pos(item.sensed_position);
    goal         = clamp_pos(item.goal_position);
    pos_plus_tol = {1'b0, pos} + {1'b0, cfg.target_tolerance};
    tgt_plus_tol = {1'b0, cur.target_reg} + {1'b0, cfg.target_tolerance};
    pub_cnt      = cur.publish_timer;
    nxt          = cur;
    flags        = '0;

    case (item.kind)
      KIND_TICK: begin
        nxt.position_reg = pos;
        if (pub_cnt != TIMER_MAX) begin
          pub_cnt = pub_cnt + 1'b1;
        end
        if (pub_cnt > cfg.publish_period_ms) begin
          flags.publish = 1'b1;
          pub_cnt = '0;
        end
        nxt.publish_timer = pub_cnt;

        if (cur.motion_state == MOT_IDLE) begin
          nxt.open_duty   = '0;
          nxt.close_duty  = '0;
          nxt.stall_timer = '0;
          nxt.stall_armed = 1'b0;
        end else begin
          if (cur.previous_position != pos) begin
            nxt.previous_position = pos;
            nxt.stall_timer       = '0;
            nxt.stall_armed       = 1'b1;
          end else if (cur.stall_timer != TIMER_MAX) begin
            nxt.stall_timer = cur.stall_timer + 1'b1;
          end
          if (nxt.stall_armed && nxt.stall_timer > cfg.stall_limit_ms) begin
            nxt.motion_state  = MOT_IDLE;
            nxt.open_duty     = '0;
            nxt.close_duty    = '0;
            flags.publish     = 1'b1;
            flags.forced_stop = 1'b1;
          end
        end

        // opposite drive is cleared for one tick before driving
        if (nxt.motion_state == MOT_OPENING) begin
          if (nxt.close_duty != '0) begin
            nxt.close_duty = '0;
          end else if (item.at_open_end ||
                       (cur.target_reg != FULL_SCALE &&
                        pos_plus_tol > {1'b0, cur.target_reg})) begin
            nxt.motion_state = MOT_IDLE;
            nxt.open_duty    = '0;
            flags.publish    = 1'b1;
          end else begin
            nxt.open_duty = item.near_open_end ? power : FULL_SCALE;
          end
        end else if (nxt.motion_state == MOT_CLOSING) begin
          if (nxt.open_duty != '0) begin
            nxt.open_duty = '0;
          end else if (item.at_closed_end ||
                       (cur.target_reg != '0 &&
                        {1'b0, pos} < tgt_plus_tol)) begin
            nxt.motion_state = MOT_IDLE;
            nxt.close_duty   = '0;
            flags.publish    = 1'b1;
          end else begin
            nxt.close_duty = item.near_closed_end ? power : FULL_SCALE;
          end
        end
      end
      KIND_STOP: begin
        nxt.motion_state = MOT_IDLE;
        nxt.open_duty    = '0;
        nxt.close_duty   = '0;
        flags.publish    = 1'b1;
      end
      KIND_MOVE: begin
        if (goal != cur.position_reg) begin
          nxt.target_reg   = goal;
          nxt.motion_state = (goal < cur.position_reg) ? MOT_CLOSING : MOT_OPENING;
          nxt.stall_timer  = '0;
          nxt.stall_armed  = 1'b1;
          flags.publish    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* tb/cover_motor_drive_controller_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cover_motor_drive_controller_tb
// Self-checking bench for the cover drive controller. A directed sequence
// covers end stops, the target window, the drive handover, stall timeout,
// stop, unused kinds and saturation. Random phases then run simulated cover
// trips plus noise under several register settings. The bench predicts each
// result and checks it in order. Both sides idle at random, and the
// receiver holds off for long stretches now and then.
// ----------------------------------------------------------------------------
module cover_motor_drive_controller_tb;
  import cmdc_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] open_drive;
    logic [POS_W-1:0] close_drive;
    logic [1:0]       motion;
    logic [POS_W-1:0] reported_position;
    logic             publish;
    logic             forced_stop;
  } drive_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         kind;
  logic [POS_W-1:0]   sensed_position;
  logic [POS_W-1:0]   goal_position;
  logic               at_open_end;
  logic               near_open_end;
  logic               at_closed_end;
  logic               near_closed_end;
  logic               out_valid;
  logic               out_stall;
  logic [POS_W-1:0]   open_drive;
  logic [POS_W-1:0]   close_drive;
  logic [1:0]         motion;
  logic [POS_W-1:0]   reported_position;
  logic               publish;
  logic               forced_stop;

  item_t         tx_item = '0;
  item_t         pending_items[$];
  drive_result_t expected_results[$];
  cfg_t          drv_cfg;
  state_t        cover_st;

  int  tx_wait;
  int  rx_wait;
  int  hold_left;
  int  hold_gap;
  logic rx_stall = 1'b0;
  bit  tx_steady;
  bit  rx_steady;
  int  error_count;
  int  stim_count;
  int  sim_pos;

  assign kind            = tx_item.kind;
  assign sensed_position = tx_item.sensed_position;
  assign goal_position   = tx_item.goal_position;
  assign at_open_end     = tx_item.at_open_end;
  assign near_open_end   = tx_item.near_open_end;
  assign at_closed_end   = tx_item.at_closed_end;
  assign near_closed_end = tx_item.near_closed_end;
  assign out_stall       = rx_stall | (hold_left != 0);

  cover_motor_drive_controller u_dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [POS_W-1:0] limit_to_full(input logic [POS_W-1:0] v);
    return (v > FULL_SCALE) ? FULL_SCALE : v;
  endfunction

  function automatic drive_result_t predict_drive(input item_t it);
    drive_result_t    res;
    logic [POS_W-1:0] duty_near;
    logic [POS_W-1:0] goal;
    logic             pub;
    logic             forced;
    pub = 1'b0;
    forced = 1'b0;
    duty_near = (drv_cfg.near_end_power > FULL_SCALE) ? FULL_SCALE : drv_cfg.near_end_power;
    case (it.kind)
      KIND_TICK: begin
        cover_st.position_reg = limit_to_full(it.sensed_position);
        if (cover_st.publish_timer != TIMER_MAX)
          cover_st.publish_timer = cover_st.publish_timer + 1'b1;
        if (cover_st.publish_timer > drv_cfg.publish_period_ms) begin
          pub = 1'b1;
          cover_st.publish_timer = '0;
        end
        if (cover_st.motion_state == MOT_IDLE) begin
          cover_st.open_duty = '0;
          cover_st.close_duty = '0;
          cover_st.stall_timer = '0;
          cover_st.stall_armed = 1'b0;
        end else begin
          if (cover_st.previous_position != cover_st.position_reg) begin
            cover_st.previous_position = cover_st.position_reg;
            cover_st.stall_timer = '0;
            cover_st.stall_armed = 1'b1;
          end else if (cover_st.stall_timer != TIMER_MAX) begin
            cover_st.stall_timer = cover_st.stall_timer + 1'b1;
          end
          if (cover_st.stall_armed && cover_st.stall_timer > drv_cfg.stall_limit_ms) begin
            cover_st.motion_state = MOT_IDLE;
            cover_st.open_duty = '0;
            cover_st.close_duty = '0;
            pub = 1'b1;
            forced = 1'b1;
          end
        end
        // the opposite drive must be released for one tick before driving
        if (cover_st.motion_state == MOT_OPENING) begin
          if (cover_st.close_duty != '0) begin
            cover_st.close_duty = '0;
          end else if (it.at_open_end || (cover_st.target_reg != FULL_SCALE &&
              ({1'b0, cover_st.position_reg} + {1'b0, drv_cfg.target_tolerance}) >
              {1'b0, cover_st.target_reg})) begin
            cover_st.motion_state = MOT_IDLE;
            cover_st.open_duty = '0;
            pub = 1'b1;
          end else begin
            cover_st.open_duty = it.near_open_end ? duty_near : FULL_SCALE;
          end
        end else if (cover_st.motion_state == MOT_CLOSING) begin
          if (cover_st.open_duty != '0) begin
            cover_st.open_duty = '0;
          end else if (it.at_closed_end || (cover_st.target_reg != '0 &&
              {1'b0, cover_st.position_reg} <
              ({1'b0, cover_st.target_reg} + {1'b0, drv_cfg.target_tolerance}))) begin
            cover_st.motion_state = MOT_IDLE;
            cover_st.close_duty = '0;
            pub = 1'b1;
          end else begin
            cover_st.close_duty = it.near_closed_end ? duty_near : FULL_SCALE;
          end
        end
      end
      KIND_STOP: begin
        cover_st.motion_state = MOT_IDLE;
        cover_st.open_duty = '0;
        cover_st.close_duty = '0;
        pub = 1'b1;
      end
      KIND_MOVE: begin
        goal = limit_to_full(it.goal_position);
        if (goal != cover_st.position_reg) begin
          cover_st.target_reg = goal;
          cover_st.motion_state = (goal < cover_st.position_reg) ? MOT_CLOSING : MOT_OPENING;
          cover_st.stall_timer = '0;
          cover_st.stall_armed = 1'b1;
          pub = 1'b1;
        end
      end
      default: ;
    endcase
    res.open_drive = cover_st.open_duty;
    res.close_drive = cover_st.close_duty;
    res.motion = cover_st.motion_state;
    res.reported_position = cover_st.position_reg;
    res.publish = pub;
    res.forced_stop = forced;
    return res;
  endfunction

  // ------------------------------------------------------------------- driver
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_results.push_back(predict_drive(tx_item));
      if (in_valid && in_stall) begin
        // hold the transaction until it is taken
      end else if (tx_wait != 0) begin
        in_valid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (pending_items.size() != 0) begin
        tx_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        tx_wait <= tx_steady ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------ monitor
  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    drive_result_t want;
    int            n;
    if (rst) begin
      rx_stall <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual motion %0d pos %0d",
                   $time, motion, reported_position);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("open_drive", want.open_drive, open_drive);
          compare_field("close_drive", want.close_drive, close_drive);
          compare_field("motion", want.motion, motion);
          compare_field("reported_position", want.reported_position, reported_position);
          compare_field("publish", want.publish, publish);
          compare_field("forced_stop", want.forced_stop, forced_stop);
        end
      end
      if (rx_wait != 0) begin
        rx_stall <= 1'b1;
        rx_wait <= rx_wait - 1;
      end else begin
        n = rx_steady ? 0 : idle_len();
        rx_stall <= (n != 0);
        rx_wait <= (n != 0) ? n - 1 : 0;
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_gap <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_gap != 0) begin
      hold_gap <= hold_gap - 1;
    end else if (in_valid) begin
      hold_left <= $urandom_range(120, 250);
      hold_gap <= $urandom_range(1500, 3000);
    end
  end

  // ----------------------------------------------------------------- stimulus
  task automatic push_item(input logic [1:0] k, input int sensed, input int goal,
                           input logic [3:0] flags);
    item_t it;
    it.kind = k;
    it.sensed_position = sensed[POS_W-1:0];
    it.goal_position = goal[POS_W-1:0];
    {it.at_open_end, it.near_open_end, it.at_closed_end, it.near_closed_end} = flags;
    pending_items.push_back(it);
    stim_count++;
  endtask

  function automatic logic [3:0] end_flags(input int p);
    logic [3:0] f;
    f = {p >= 1024, p >= 900, p <= 0, p <= 124};
    if ($urandom_range(0, 19) == 0)
      f = 4'($urandom_range(0, 15));
    return f;
  endfunction

  task automatic push_tick();
    int sensed;
    sensed = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 2047) : sim_pos;
    push_item(KIND_TICK, sensed, $urandom_range(0, 2047), end_flags(sim_pos));
  endtask

  task automatic push_noise();
    push_item(2'($urandom_range(0, 3)), $urandom_range(0, 2047), $urandom_range(0, 2047),
              4'($urandom_range(0, 15)));
  endtask

  // move command followed by ticks of a cover heading for the goal;
  // a jammed trip barely moves so the stall timeout can fire
  task automatic cover_trip();
    int r;
    int goal;
    int dest;
    int n;
    int step;
    bit jammed;
    r = $urandom_range(0, 9);
    case (r)
      0: goal = 0;
      1: goal = 1024;
      2: goal = $urandom_range(1025, 2047);
      3: goal = sim_pos;
      default: goal = $urandom_range(0, 1024);
    endcase
    dest = (goal > 1024) ? 1024 : goal;
    push_item(KIND_MOVE, $urandom_range(0, 2047), goal, 4'($urandom_range(0, 15)));
    n = $urandom_range(4, 40);
    jammed = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      step = $urandom_range(0, 50);
      if (jammed && $urandom_range(0, 5) != 0)
        step = 0;
      if (sim_pos < dest)
        sim_pos = (sim_pos + step > 1024) ? 1024 : sim_pos + step;
      else if (sim_pos > dest)
        sim_pos = (sim_pos - step < 0) ? 0 : sim_pos - step;
      push_tick();
      if ($urandom_range(0, 79) == 0)
        push_item(KIND_STOP, $urandom_range(0, 2047), $urandom_range(0, 2047),
                  4'($urandom_range(0, 15)));
    end
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_NEAR_END_POWER:    drv_cfg.near_end_power = data[POS_W-1:0];
      REG_TARGET_TOLERANCE:  drv_cfg.target_tolerance = data[POS_W-1:0];
      REG_STALL_LIMIT_MS:    drv_cfg.stall_limit_ms = data;
      REG_PUBLISH_PERIOD_MS: drv_cfg.publish_period_ms = data;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] power, input logic [CFG_W-1:0] tol,
                              input logic [CFG_W-1:0] stall, input logic [CFG_W-1:0] period);
    write_reg(REG_NEAR_END_POWER, power);
    write_reg(REG_TARGET_TOLERANCE, tol);
    write_reg(REG_STALL_LIMIT_MS, stall);
    write_reg(REG_PUBLISH_PERIOD_MS, period);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] power;
    logic [CFG_W-1:0] tol;
    logic [CFG_W-1:0] stall;
    logic [CFG_W-1:0] period;
    int               phase_end;
    drv_cfg.near_end_power = 11'd512;
    drv_cfg.target_tolerance = 11'd102;
    drv_cfg.stall_limit_ms = 16'd4000;
    drv_cfg.publish_period_ms = 16'd1000;
    cover_st = '0;
    cover_st.motion_state = MOT_IDLE;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: end stops, target window, drive handover, stall, stop, odd kinds
    program_regs(16'd300, 16'd102, 16'd3, 16'd5);
    @(negedge clk);
    push_item(KIND_TICK, 0, 0, 4'b0000);
    push_item(2'd3, 700, 900, 4'b1111);
    push_item(KIND_MOVE, 0, 0, 4'b0000);
    push_item(KIND_MOVE, 0, 2047, 4'b0000);
    push_item(KIND_TICK, 2047, 0, 4'b0100);
    push_item(KIND_TICK, 600, 0, 4'b0000);
    push_item(KIND_MOVE, 0, 100, 4'b0000);
    push_item(KIND_TICK, 600, 0, 4'b0000);
    push_item(KIND_TICK, 590, 0, 4'b0001);
    repeat (4) push_item(KIND_TICK, 590, 0, 4'b0000);
    push_item(KIND_MOVE, 0, 1024, 4'b0000);
    push_item(KIND_TICK, 1024, 0, 4'b1100);
    push_item(KIND_MOVE, 0, 0, 4'b0000);
    push_item(KIND_TICK, 500, 0, 4'b0000);
    push_item(KIND_TICK, 0, 0, 4'b0011);
    push_item(KIND_MOVE, 0, 500, 4'b0000);
    push_item(KIND_TICK, 420, 0, 4'b0000);
    push_item(KIND_MOVE, 0, 300, 4'b0000);
    push_item(KIND_TICK, 390, 0, 4'b0000);
    push_item(KIND_MOVE, 0, 800, 4'b0000);
    push_item(KIND_TICK, 450, 0, 4'b0000);
    push_item(KIND_STOP, 2047, 2047, 4'b1111);
    push_item(KIND_TICK, 450, 0, 4'b0000);
    sim_pos = 450;
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin power = 16'd0; tol = 16'd0; stall = 16'd1; period = 16'd0; end
        1: begin power = 16'd1024; tol = 16'd1024; stall = 16'hFFFF; period = 16'hFFFF; end
        2: begin power = 16'hFFFF; tol = 16'd60; stall = 16'd0; period = 16'd3; end
        default: begin
          power = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(0, 1024));
          tol = 16'($urandom_range(0, 200));
          stall = 16'($urandom_range(1, 25));
          period = 16'($urandom_range(1, 60));
        end
      endcase
      tx_steady = (p == 1) || (p == 5);
      rx_steady = (p == 1) || (p == 6);
      program_regs(power, tol, stall, period);
      @(negedge clk);
      phase_end = stim_count + 205;
      while (stim_count < phase_end) begin
        if ($urandom_range(0, 99) < 15)
          push_noise();
        else
          cover_trip();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
design/cmdc_pkg.sv
design/cmdc_step.sv
design/cover_motor_drive_controller.sv
tb/cover_motor_drive_controller_tb.sv
